// ===== design/prfl_pkg.sv =====
// shared constants and types for the page replacement frame table
`default_nettype none

package prfl_pkg;

    localparam int FRAMES_DEF     = 16;
    localparam int PID_BITS_DEF   = 8;
    localparam int PAGE_BITS_DEF  = 16;

    localparam int FRAME_COUNT_W  = 5;
    localparam int FRAME_INDEX_W  = 4;
    localparam int FAULT_W        = 32;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RST = 5'd16;

    // register select, taken from paddr[2]
    localparam logic REG_POLICY      = 1'b0;
    localparam logic REG_FRAME_COUNT = 1'b1;

    typedef enum logic {
        POLICY_FIFO = 1'b0,
        POLICY_LRU  = 1'b1
    } policy_t;

    // update requested of the eviction order list
    typedef struct packed {
        logic append;   // new frame filled, goes to tail
        logic promote;  // hit frame moves to tail
        logic rotate;   // head evicted, goes to tail
    } order_op_t;

endpackage

`default_nettype wire

// ===== design/prfl_tag_table.sv =====
// frame tag store with parallel lookup and victim tag read
`default_nettype none

module prfl_tag_table #(
    parameter int FRAMES    = 16,
    parameter int PID_BITS  = 8,
    parameter int PAGE_BITS = 16,
    parameter int FIDX      = 4,
    parameter int UW        = 5
) (
    input  wire logic                 aclk,
    input  wire logic [UW-1:0]        frames_used,
    input  wire logic [PID_BITS-1:0]  lookup_pid,
    input  wire logic [PAGE_BITS-1:0] lookup_page,
    output logic                      match,
    output logic [FIDX-1:0]           match_frame,
    input  wire logic [FIDX-1:0]      victim_frame,
    output logic [PID_BITS-1:0]       victim_pid,
    output logic [PAGE_BITS-1:0]      victim_page,
    input  wire logic                 wr_en,
    input  wire logic [FIDX-1:0]      wr_frame,
    input  wire logic [PID_BITS-1:0]  wr_pid,
    input  wire logic [PAGE_BITS-1:0] wr_page
);

    logic [PID_BITS-1:0]  tag_pid_reg  [FRAMES];
    logic [PAGE_BITS-1:0] tag_page_reg [FRAMES];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tag_pid_reg[wr_frame]  <= wr_pid;
            tag_page_reg[wr_frame] <= wr_page;
        end
    end

    // lowest occupied frame that matches wins
    always_comb begin
        match       = 1'b0;
        match_frame = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if ((UW'(i) < frames_used) && (tag_pid_reg[i] == lookup_pid) &&
                (tag_page_reg[i] == lookup_page)) begin
                match       = 1'b1;
                match_frame = FIDX'(i);
            end
        end
    end

    assign victim_pid  = tag_pid_reg[victim_frame];
    assign victim_page = tag_page_reg[victim_frame];

endmodule

`default_nettype wire

// ===== design/prfl_order_list.sv =====
// eviction order list: head is the next victim, tail the newest or most recent
`default_nettype none

module prfl_order_list #(
    parameter int FRAMES = 16,
    parameter int FIDX   = 4,
    parameter int UW     = 5
) (
    input  wire logic                aclk,
    input  wire prfl_pkg::order_op_t op,
    input  wire logic [FIDX-1:0]     frame,
    input  wire logic [UW-1:0]       frames_used,
    output logic [FIDX-1:0]          head
);

    import prfl_pkg::*;

    logic [FIDX-1:0] order_reg  [FRAMES];
    logic [FIDX-1:0] order_next [FRAMES];
    logic [FIDX-1:0] order_up   [FRAMES];
    logic [UW-1:0]   pos;
    logic [FIDX-1:0] moved;
    logic            shift_en;

    // neighbor toward the tail for each position
    for (genvar g = 0; g < FRAMES; g++) begin : g_up
        if (g < FRAMES - 1) begin : g_mid
            assign order_up[g] = order_reg[g+1];
        end else begin : g_last
            assign order_up[g] = '0;
        end
    end

    // list position of the promoted frame
    always_comb begin
        pos = '0;
        for (int i = 0; i < FRAMES; i++) begin
            if (op.promote && (UW'(i) < frames_used) && (order_reg[i] == frame)) begin
                pos = UW'(i);
            end
        end
    end

    assign shift_en = op.promote || op.rotate;
    assign moved    = op.rotate ? order_reg[0] : frame;

    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            order_next[i] = order_reg[i];
            if (shift_en && (UW'(i) >= pos)) begin
                if ((UW'(i) + UW'(1)) < frames_used) begin
                    order_next[i] = order_up[i];
                end else if ((UW'(i) + UW'(1)) == frames_used) begin
                    order_next[i] = moved;
                end
            end
            if (op.append && (UW'(i) == frames_used)) begin
                order_next[i] = FIDX'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < FRAMES; i++) begin
            order_reg[i] <= order_next[i];
        end
    end

    assign head = order_reg[0];

endmodule

`default_nettype wire

// ===== design/page_replacement_fifo_lru.sv =====
// page replacement frame table top level with FIFO and LRU eviction
//
//  port group   dir   handshake           word
//  s_*          in    s_valid / s_ready   process_id, page_number
//  m_*          out   m_valid / m_ready   hit, frame, evicted pair, fault count
//  apb          in    psel/penable        policy, frame_count
//
//  one word per cycle sustained while the m_ side is not stalled; s_ valid reaches m_ valid
//  through the input register, then lookup and table update into the result register
//  the lookup, tag write and order list shift all settle in the same cycle
//  reset clears occupancy and the fault count at once, no clearing pass
//  a stalled m_ side holds the result register and backs up into the input register
`default_nettype none

module page_replacement_fifo_lru #(
    parameter int FRAMES    = prfl_pkg::FRAMES_DEF,
    parameter int PID_BITS  = prfl_pkg::PID_BITS_DEF,
    parameter int PAGE_BITS = prfl_pkg::PAGE_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [PID_BITS-1:0]              s_process_id,
    input  wire logic [PAGE_BITS-1:0]             s_page_number,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_hit,
    output logic [prfl_pkg::FRAME_INDEX_W-1:0]    m_frame_index,
    output logic                                  m_evicted_valid,
    output logic [PID_BITS-1:0]                   m_evicted_process,
    output logic [PAGE_BITS-1:0]                  m_evicted_page,
    output logic [prfl_pkg::FAULT_W-1:0]          m_fault_count,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [prfl_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [prfl_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [prfl_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);

    import prfl_pkg::*;

    localparam int FIDX = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int UW   = $clog2(FRAMES + 1);
    localparam int CW   = (UW > FRAME_COUNT_W) ? UW : FRAME_COUNT_W;

    // configuration
    policy_t                  policy_reg;
    logic [FRAME_COUNT_W-1:0] frame_count_reg;

    // input register
    logic                 in_valid_reg;
    logic [PID_BITS-1:0]  in_pid_reg;
    logic [PAGE_BITS-1:0] in_page_reg;

    // table state
    logic [UW-1:0]      frames_used_reg;
    logic [UW-1:0]      frames_used_next;
    logic [FAULT_W-1:0] faults_reg;
    logic [FAULT_W-1:0] faults_next;

    // result register
    logic                 out_valid_reg;
    logic                 out_hit_reg;
    logic [FIDX-1:0]      out_frame_reg;
    logic                 out_ev_valid_reg;
    logic [PID_BITS-1:0]  out_ev_pid_reg;
    logic [PAGE_BITS-1:0] out_ev_page_reg;
    logic [FAULT_W-1:0]   out_faults_reg;

    logic                 advance;
    logic                 process;
    logic                 match;
    logic [FIDX-1:0]      match_frame;
    logic [FIDX-1:0]      head;
    logic [PID_BITS-1:0]  victim_pid;
    logic [PAGE_BITS-1:0] victim_page;
    logic [CW-1:0]        used_w;
    logic [CW-1:0]        count_w;
    logic [CW-1:0]        limit;
    logic                 has_free;
    logic                 do_fill;
    logic                 do_evict;
    logic [FIDX-1:0]      frame_sel;
    logic [FIDX-1:0]      tag_wr_frame;
    order_op_t            order_op;
    logic                 cfg_wr;
    logic [FIDX+FRAME_INDEX_W-1:0] frame_wide;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg      <= POLICY_FIFO;
            frame_count_reg <= FRAME_COUNT_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_POLICY:      policy_reg      <= policy_t'(pwdata[0]);
                REG_FRAME_COUNT: frame_count_reg <= pwdata[FRAME_COUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_POLICY:      prdata = APB_DATA_W'(policy_reg);
            REG_FRAME_COUNT: prdata = APB_DATA_W'(frame_count_reg);
            default:         prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign process = in_valid_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_pid_reg  <= s_process_id;
            in_page_reg <= s_page_number;
        end
    end

    // ---------------- lookup and replacement decision ----------------
    prfl_tag_table #(
        .FRAMES    (FRAMES),
        .PID_BITS  (PID_BITS),
        .PAGE_BITS (PAGE_BITS),
        .FIDX      (FIDX),
        .UW        (UW)
    ) u_tags (
        .aclk         (aclk),
        .frames_used  (frames_used_reg),
        .lookup_pid   (in_pid_reg),
        .lookup_page  (in_page_reg),
        .match        (match),
        .match_frame  (match_frame),
        .victim_frame (head),
        .victim_pid   (victim_pid),
        .victim_page  (victim_page),
        .wr_en        (process && !match),
        .wr_frame     (tag_wr_frame),
        .wr_pid       (in_pid_reg),
        .wr_page      (in_page_reg)
    );

    prfl_order_list #(
        .FRAMES (FRAMES),
        .FIDX   (FIDX),
        .UW     (UW)
    ) u_order (
        .aclk        (aclk),
        .op          (order_op),
        .frame       (match_frame),
        .frames_used (frames_used_reg),
        .head        (head)
    );

    // frame_count of zero acts as one, above FRAMES acts as FRAMES
    always_comb begin
        used_w  = CW'(frames_used_reg);
        count_w = CW'(frame_count_reg);
        if (count_w == '0) begin
            limit = CW'(1);
        end else if (count_w > CW'(FRAMES)) begin
            limit = CW'(FRAMES);
        end else begin
            limit = count_w;
        end
    end

    assign has_free     = used_w < limit;
    assign do_fill      = !match && has_free;
    assign do_evict     = !match && !has_free;
    assign tag_wr_frame = do_fill ? FIDX'(frames_used_reg) : head;
    assign frame_sel    = match ? match_frame : tag_wr_frame;

    assign order_op.append  = process && do_fill;
    assign order_op.promote = process && match && (policy_reg == POLICY_LRU);
    assign order_op.rotate  = process && do_evict;

    always_comb begin
        frames_used_next = frames_used_reg;
        faults_next      = faults_reg;
        if (process && do_fill) begin
            frames_used_next = frames_used_reg + UW'(1);
        end
        if (process && !match && (faults_reg != '1)) begin
            faults_next = faults_reg + FAULT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_used_reg <= '0;
            faults_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            frames_used_reg <= frames_used_next;
            faults_reg      <= faults_next;
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (process) begin
            out_hit_reg      <= match;
            out_frame_reg    <= frame_sel;
            out_ev_valid_reg <= do_evict;
            out_ev_pid_reg   <= do_evict ? victim_pid : '0;
            out_ev_page_reg  <= do_evict ? victim_page : '0;
            out_faults_reg   <= faults_next;
        end
    end

    // ---------------- result port ----------------
    assign frame_wide        = {{FRAME_INDEX_W{1'b0}}, out_frame_reg};
    assign m_valid           = out_valid_reg;
    assign m_hit             = out_hit_reg;
    assign m_frame_index     = frame_wide[FRAME_INDEX_W-1:0];
    assign m_evicted_valid   = out_ev_valid_reg;
    assign m_evicted_process = out_ev_pid_reg;
    assign m_evicted_page    = out_ev_page_reg;
    assign m_fault_count     = out_faults_reg;

    // ---------------- assertions ----------------
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        frames_used_reg <= UW'(FRAMES))
        else $error("occupancy above frame total");

    a_fault_step: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn |=> ((faults_reg == $past(faults_reg)) ||
                     ({1'b0, faults_reg} == {1'b0, $past(faults_reg)} + 33'd1)))
        else $error("fault count moved by other than zero or one");

    a_evict_on_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_hit_reg && out_ev_valid_reg))
        else $error("eviction reported on a hit");

    a_fill_only_on_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn |=> ((frames_used_reg == $past(frames_used_reg)) ||
                     ($past(process) && !$past(match))))
        else $error("occupancy changed without a miss");

endmodule

`default_nettype wire

// ===== test/tb_page_replacement_fifo_lru.sv =====
// testbench for the page replacement frame table: directed and random fifo/lru access streams against a predictor

module tb_page_replacement_fifo_lru;
    import prfl_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 48;
    localparam int POOL_MAX    = 40;

    typedef struct packed {
        logic                     hit;
        logic [FRAME_INDEX_W-1:0] frame_index;
        logic                     evicted_valid;
        logic [PID_BITS_DEF-1:0]  evicted_process;
        logic [PAGE_BITS_DEF-1:0] evicted_page;
        logic [FAULT_W-1:0]       fault_count;
    } access_result_t;

    // tracks which pairs are resident and what each access must report
    class residency_board;
        logic [PID_BITS_DEF-1:0]  tag_pid [FRAMES_DEF];
        logic [PAGE_BITS_DEF-1:0] tag_page [FRAMES_DEF];
        logic [FRAME_INDEX_W-1:0] victim_order [FRAMES_DEF];
        int unsigned              occupied;
        logic [FAULT_W-1:0]       faults;
        policy_t                  policy;
        logic [FRAME_COUNT_W-1:0] frame_limit;
        access_result_t           due_results [$];
        int unsigned              mismatches;
        int unsigned              hits_seen;
        int unsigned              evictions_seen;
        int unsigned              results_checked;

        function new();
            occupied        = 0;
            faults          = '0;
            policy          = POLICY_FIFO;
            frame_limit     = FRAME_COUNT_RST;
            mismatches      = 0;
            hits_seen       = 0;
            evictions_seen  = 0;
            results_checked = 0;
        endfunction

        function void move_to_back(int unsigned pos);
            logic [FRAME_INDEX_W-1:0] f;
            f = victim_order[pos];
            for (int unsigned i = pos; i + 1 < occupied; i++)
                victim_order[i] = victim_order[i + 1];
            victim_order[occupied - 1] = f;
        endfunction

        function void note_access(logic [PID_BITS_DEF-1:0] pid, logic [PAGE_BITS_DEF-1:0] page);
            access_result_t r;
            int             found_at;
            int unsigned    lim;
            int unsigned    f;
            r = '0;
            found_at = -1;
            for (int i = 0; i < int'(occupied); i++) begin
                if (tag_pid[i] == pid && tag_page[i] == page) begin
                    found_at = i;
                    break;
                end
            end
            if (found_at >= 0) begin
                r.hit = 1'b1;
                f = found_at;
                hits_seen++;
                if (policy == POLICY_LRU) begin
                    for (int unsigned j = 0; j < occupied; j++) begin
                        if (32'(victim_order[j]) == f) begin
                            move_to_back(j);
                            break;
                        end
                    end
                end
            end else begin
                if (faults != '1)
                    faults++;
                lim = (frame_limit == '0) ? 1 :
                      (32'(frame_limit) > FRAMES_DEF) ? FRAMES_DEF : 32'(frame_limit);
                if (occupied < lim) begin
                    f = occupied;
                    victim_order[occupied] = FRAME_INDEX_W'(f);
                    occupied++;
                end else begin
                    // head of the order list is the victim, then it goes to the tail
                    f = 32'(victim_order[0]);
                    r.evicted_valid   = 1'b1;
                    r.evicted_process = tag_pid[f];
                    r.evicted_page    = tag_page[f];
                    evictions_seen++;
                    move_to_back(0);
                end
                tag_pid[f]  = pid;
                tag_page[f] = page;
            end
            r.frame_index = FRAME_INDEX_W'(f);
            r.fault_count = faults;
            due_results.insert(due_results.size(), r);
        endfunction

        function void check_result(access_result_t got);
            access_result_t want;
            if (due_results.size() == 0) begin
                $error("result word arrived with no access waiting");
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            results_checked++;
            if (got.hit !== want.hit) begin
                $error("hit: expected %0d, got %0d", want.hit, got.hit);
                mismatches++;
            end
            if (got.frame_index !== want.frame_index) begin
                $error("frame_index: expected %0d, got %0d", want.frame_index, got.frame_index);
                mismatches++;
            end
            if (got.evicted_valid !== want.evicted_valid) begin
                $error("evicted_valid: expected %0d, got %0d",
                       want.evicted_valid, got.evicted_valid);
                mismatches++;
            end
            if (got.evicted_process !== want.evicted_process) begin
                $error("evicted_process: expected %0h, got %0h",
                       want.evicted_process, got.evicted_process);
                mismatches++;
            end
            if (got.evicted_page !== want.evicted_page) begin
                $error("evicted_page: expected %0h, got %0h",
                       want.evicted_page, got.evicted_page);
                mismatches++;
            end
            if (got.fault_count !== want.fault_count) begin
                $error("fault_count: expected %0d, got %0d", want.fault_count, got.fault_count);
                mismatches++;
            end
        endfunction
    endclass

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic [PID_BITS_DEF-1:0]    s_process_id;
    logic [PAGE_BITS_DEF-1:0]   s_page_number;
    logic                       m_valid;
    logic                       m_ready;
    logic                       m_hit;
    logic [FRAME_INDEX_W-1:0]   m_frame_index;
    logic                       m_evicted_valid;
    logic [PID_BITS_DEF-1:0]    m_evicted_process;
    logic [PAGE_BITS_DEF-1:0]   m_evicted_page;
    logic [FAULT_W-1:0]         m_fault_count;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [APB_ADDR_W-1:0]      paddr;
    logic [APB_DATA_W-1:0]      pwdata;
    logic [APB_DATA_W-1:0]      prdata;
    logic                       pready;

    residency_board board = new();
    int unsigned    cycle_count;
    int unsigned    words_sent;
    int unsigned    configs_applied;
    int unsigned    send_idle_pct;
    int unsigned    recv_idle_pct;
    bit             hold_off_req;

    page_replacement_fifo_lru dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_process_id      (s_process_id),
        .s_page_number     (s_page_number),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_hit             (m_hit),
        .m_frame_index     (m_frame_index),
        .m_evicted_valid   (m_evicted_valid),
        .m_evicted_process (m_evicted_process),
        .m_evicted_page    (m_evicted_page),
        .m_fault_count     (m_fault_count),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    task automatic send_word(input logic [PID_BITS_DEF-1:0] pid,
                             input logic [PAGE_BITS_DEF-1:0] page);
        s_valid       <= 1'b1;
        s_process_id  <= pid;
        s_page_number <= page;
        do @(posedge aclk); while (!s_ready);
        board.note_access(pid, page);
        words_sent++;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    task automatic apb_write(input logic reg_sel, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        while (board.due_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure(input policy_t pol, input logic [FRAME_COUNT_W-1:0] limit);
        wait_drained();
        apb_write(REG_POLICY, APB_DATA_W'(pol));
        apb_write(REG_FRAME_COUNT, APB_DATA_W'(limit));
        board.policy      = pol;
        board.frame_limit = limit;
        configs_applied++;
    endtask

    // mostly re-references a working set so hits, refills and evictions all occur
    task automatic random_phase(input policy_t pol, input logic [FRAME_COUNT_W-1:0] limit,
                                input int unsigned n_words, input int unsigned idle_pct,
                                input bit long_hold);
        logic [PID_BITS_DEF-1:0]  pool_pid [POOL_MAX];
        logic [PAGE_BITS_DEF-1:0] pool_page [POOL_MAX];
        int unsigned              pool_len;
        int unsigned              eff;
        int unsigned              idx;
        configure(pol, limit);
        eff = (limit == '0) ? 1 : (32'(limit) > FRAMES_DEF) ? FRAMES_DEF : 32'(limit);
        pool_len = $urandom_range(1, 2 * eff + 2);
        for (int unsigned k = 0; k < pool_len; k++) begin
            // near neighbors share one field so the compare must check both
            pool_pid[k]  = (k > 0 && $urandom_range(0, 3) == 0) ? pool_pid[k - 1]
                                                                : 8'($urandom_range(0, 255));
            pool_page[k] = (k > 0 && $urandom_range(0, 3) == 0) ? pool_page[k - 1]
                                                                : 16'($urandom_range(0, 65535));
        end
        send_idle_pct = idle_pct;
        recv_idle_pct = idle_pct;
        if (long_hold) begin
            send_idle_pct = 0;
            hold_off_req  = 1'b1;
        end
        for (int unsigned n = 0; n < n_words; n++) begin
            if ($urandom_range(0, 99) < 85) begin
                idx = $urandom_range(0, pool_len - 1);
                send_word(pool_pid[idx], pool_page[idx]);
            end else begin
                send_word(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
            end
            if (long_hold && n == 60)
                send_idle_pct = idle_pct;
        end
        s_valid <= 1'b0;
    endtask

    // receiver side: random short stalls, one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if ($urandom_range(0, 99) < recv_idle_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result('{m_hit, m_frame_index, m_evicted_valid,
                                 m_evicted_process, m_evicted_page, m_fault_count});
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $error("run timed out with %0d results outstanding", board.due_results.size());
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_process_id    = '0;
        s_page_number   = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        hold_off_req    = 1'b0;
        words_sent      = 0;
        configs_applied = 0;
        send_idle_pct   = 15;
        recv_idle_pct   = 15;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, partial matches, fill to full, fifo evictions
        send_word(8'h00, 16'h0000);
        send_word(8'hFF, 16'hFFFF);
        send_word(8'h00, 16'h0000);
        send_word(8'hFF, 16'h0000);
        send_word(8'h00, 16'hFFFF);
        send_word(8'hFF, 16'hFFFF);
        send_word(8'hA5, 16'h5A5A);
        send_word(8'h5A, 16'hA5A5);
        for (int i = 0; i < 10; i++)
            send_word(8'(i + 1), {8'(i), 8'hC3});
        send_word(8'h77, 16'h1234);
        send_word(8'h00, 16'h0000);
        send_word(8'hFF, 16'h0000);
        send_word(8'h5A, 16'hA5A5);
        s_valid <= 1'b0;

        // limit changes never free frames; policy flips keep the order list
        random_phase(POLICY_LRU,  5'd16, 200, 15, 1'b0);
        random_phase(POLICY_FIFO, 5'd4,  180, 20, 1'b1);
        random_phase(POLICY_LRU,  5'd1,  150, 15, 1'b0);
        random_phase(POLICY_FIFO, 5'd0,  150, 25, 1'b0);
        random_phase(POLICY_LRU,  5'd31, 180, 15, 1'b0);
        random_phase(POLICY_FIFO, 5'd16, 200, 0,  1'b0);
        random_phase(POLICY_LRU,  5'd9,  190, 20, 1'b0);
        random_phase(POLICY_LRU,  5'd16, 200, 0,  1'b0);

        while (board.due_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        $display("%0d words sent over %0d register settings, %0d results checked",
                 words_sent, configs_applied, board.results_checked);
        $display("%0d hits, %0d evictions, %0d faults, %0d mismatches",
                 board.hits_seen, board.evictions_seen, board.faults, board.mismatches);
        if (board.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
